// File: sv/v3a_pkg.sv
// v3a_pkg: shared types, constants and saturation helpers of the vector alu
// used by every module of the block; depends on nothing
package v3a_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int TOL_W      = 31;
  localparam int CMD_W      = 4;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int DEN_W      = DATA_W + 1;
  localparam int REM_W      = DEN_W + 1;
  localparam int ROOT_W     = DATA_W + 1;
  localparam int ROOT_STEPS = PROD_W / 2;
  localparam int NUM_MULS   = 6;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(1) <<< (DATA_W - 1));

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_CROSS = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_DOT   = 4'd4,
    CMD_DIV   = 4'd5,
    CMD_NEG   = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_UNIT  = 4'd8,
    CMD_LERP  = 4'd9,
    CMD_L1    = 4'd10,
    CMD_EQUAL = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_DIRECT,
    K_PROD,
    K_DOT,
    K_NORM,
    K_UNIT,
    K_DIV,
    K_EQUAL
  } kind_t;

  typedef struct packed {
    word_t [2:0] r;
    word_t       sc;
    logic        eq;
    logic        sat;
    logic        dz;
  } res_t;

  typedef struct packed {
    kind_t                      kind;
    word_t [NUM_MULS-1:0]       opa;
    word_t [NUM_MULS-1:0]       opb;
    word_t [2:0]                base;
    logic                       far;
    res_t                       res;
    logic [2:0][NUM_W-1:0]      num;
    logic [2:0]                 neg;
    logic [DEN_W-1:0]           den;
  } item_t;

  typedef struct packed {
    kind_t                      kind;
    res_t                       res;
    logic [PROD_W-1:0]          sq;
    logic [2:0][NUM_W-1:0]      num;
    logic [2:0]                 neg;
    logic [DEN_W-1:0]           den;
  } back_t;

  function automatic logic over_word(input logic signed [SUM_W-1:0] x);
    return (x > SUM_MAX) || (x < SUM_MIN);
  endfunction

  function automatic word_t clamp_word(input logic signed [SUM_W-1:0] x);
    if (x > SUM_MAX) begin
      return WORD_MAX;
    end else if (x < SUM_MIN) begin
      return WORD_MIN;
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

// File: sv/v3a_front.sv
// v3a_front: takes commands, holds the tolerance register and classifies items
// into multiplier operands, direct results and divide jobs; uses v3a_pkg
module v3a_front import v3a_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              q_full,
  input  logic [CMD_W-1:0]  in_command,
  input  word_t             in_ax,
  input  word_t             in_ay,
  input  word_t             in_az,
  input  word_t             in_bx,
  input  word_t             in_by,
  input  word_t             in_bz,
  input  word_t             in_scalar_in,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TOL_W-1:0]  cfg_equal_tolerance,
  output logic              push,
  output item_t             push_item
);

  logic [TOL_W-1:0]        tol_r;
  word_t                   av [3];
  word_t                   bv [3];
  logic [DATA_W:0]         amag [3];
  logic [DATA_W:0]         dmag [3];
  logic [DATA_W:0]         dv [3];
  logic [DATA_W:0]         smag;
  logic signed [SUM_W-1:0] add_s [3];
  logic signed [SUM_W-1:0] sub_s [3];
  logic signed [SUM_W-1:0] neg_s [3];
  logic signed [SUM_W-1:0] l1_s;
  logic                    far;
  item_t                   it;

  assign cfg_ready = 1'b1;
  assign push      = start && !q_full;
  assign push_item = it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid) begin
      tol_r <= cfg_equal_tolerance;
    end
  end

  always_comb begin
    av = '{in_ax, in_ay, in_az};
    bv = '{in_bx, in_by, in_bz};
    far = 1'b0;
    smag = in_scalar_in[DATA_W-1] ? (~{1'b1, in_scalar_in} + 1'b1) : {1'b0, in_scalar_in};
    for (int i = 0; i < 3; i++) begin
      amag[i] = av[i][DATA_W-1] ? (~{1'b1, av[i]} + 1'b1) : {1'b0, av[i]};
      dv[i]   = {av[i][DATA_W-1], av[i]} - {bv[i][DATA_W-1], bv[i]};
      dmag[i] = dv[i][DATA_W] ? (~dv[i] + 1'b1) : dv[i];
      far     = far | dmag[i][DATA_W] | dmag[i][DATA_W-1];
      add_s[i] = SUM_W'(av[i]) + SUM_W'(bv[i]);
      sub_s[i] = SUM_W'(av[i]) - SUM_W'(bv[i]);
      neg_s[i] = -SUM_W'(av[i]);
    end
    l1_s = SUM_W'($signed({1'b0, amag[0]})) + SUM_W'($signed({1'b0, amag[1]}))
         + SUM_W'($signed({1'b0, amag[2]}));
  end

  always_comb begin
    it = '0;
    it.kind = K_DIRECT;
    it.far  = far;
    it.den  = smag;
    for (int i = 0; i < 3; i++) begin
      it.num[i] = NUM_W'(amag[i]) << FRAC_BITS;
    end
    unique case (cmd_t'(in_command))
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) begin
          it.res.r[i] = clamp_word(add_s[i]);
          it.res.sat  = it.res.sat | over_word(add_s[i]);
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          it.res.r[i] = clamp_word(sub_s[i]);
          it.res.sat  = it.res.sat | over_word(sub_s[i]);
        end
      end
      CMD_NEG: begin
        for (int i = 0; i < 3; i++) begin
          it.res.r[i] = clamp_word(neg_s[i]);
          it.res.sat  = it.res.sat | over_word(neg_s[i]);
        end
      end
      CMD_L1: begin
        it.res.sc  = clamp_word(l1_s);
        it.res.sat = over_word(l1_s);
      end
      CMD_CROSS: begin
        it.kind   = K_PROD;
        it.opa[0] = in_ay;  it.opb[0] = in_bz;
        it.opa[1] = in_az;  it.opb[1] = in_by;
        it.opa[2] = in_az;  it.opb[2] = in_bx;
        it.opa[3] = in_ax;  it.opb[3] = in_bz;
        it.opa[4] = in_ax;  it.opb[4] = in_by;
        it.opa[5] = in_ay;  it.opb[5] = in_bx;
      end
      CMD_SCALE: begin
        it.kind = K_PROD;
        for (int i = 0; i < 3; i++) begin
          it.opa[2*i] = av[i];
          it.opb[2*i] = in_scalar_in;
        end
      end
      CMD_LERP: begin
        it.kind = K_PROD;
        for (int i = 0; i < 3; i++) begin
          it.opa[2*i]   = in_scalar_in;
          it.opb[2*i]   = bv[i];
          it.opa[2*i+1] = in_scalar_in;
          it.opb[2*i+1] = av[i];
          it.base[i]    = av[i];
        end
      end
      CMD_DOT: begin
        it.kind = K_DOT;
        for (int i = 0; i < 3; i++) begin
          it.opa[2*i] = av[i];
          it.opb[2*i] = bv[i];
        end
      end
      CMD_NORM, CMD_UNIT: begin
        it.kind = (cmd_t'(in_command) == CMD_NORM) ? K_NORM : K_UNIT;
        for (int i = 0; i < 3; i++) begin
          it.opa[2*i] = av[i];
          it.opb[2*i] = av[i];
          it.neg[i]   = av[i][DATA_W-1];
        end
      end
      CMD_DIV: begin
        if (smag == '0) begin
          it.res.dz = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (av[i][DATA_W-1]) begin
              it.res.r[i] = WORD_MIN;
            end else if (av[i] != '0) begin
              it.res.r[i] = WORD_MAX;
            end
          end
        end else begin
          it.kind = K_DIV;
          for (int i = 0; i < 3; i++) begin
            it.neg[i] = av[i][DATA_W-1] ^ in_scalar_in[DATA_W-1];
          end
        end
      end
      CMD_EQUAL: begin
        it.kind   = K_EQUAL;
        it.opa[1] = {1'b0, tol_r};
        it.opb[1] = {1'b0, tol_r};
        for (int i = 0; i < 3; i++) begin
          it.opa[2*i] = {1'b0, dmag[i][DATA_W-2:0]};
          it.opb[2*i] = {1'b0, dmag[i][DATA_W-2:0]};
        end
      end
      default: begin
        it.kind = K_DIRECT;
      end
    endcase
  end

endmodule

// File: sv/v3a_queue.sv
// v3a_queue: short request queue between the front and the arithmetic back end
// uses v3a_pkg for the item type and depth
module v3a_queue import v3a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop,
  output item_t pop_item
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign pop      = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/v3a_arith.sv
// v3a_arith: six signed multipliers, then product sums, flooring and saturation
// uses v3a_pkg; feeds the square root pipeline
module v3a_arith import v3a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output back_t out_pay
);

  logic                     v1_r;
  item_t                    it1_r;
  logic signed [PROD_W-1:0] prod_r   [NUM_MULS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_MULS];
  logic                     v2_r;
  back_t                    pay2_r, pay2_nxt;
  logic signed [SUM_W-1:0]  vdiff [3];
  logic signed [SUM_W-1:0]  vtot  [3];
  logic signed [SUM_W-1:0]  dsum, dsh;
  logic [PROD_W-1:0]        sq;

  assign out_valid = v2_r;
  assign out_pay   = pay2_r;

  always_comb begin
    for (int k = 0; k < NUM_MULS; k++) begin
      prod_nxt[k] = PROD_W'($signed(in_item.opa[k])) * PROD_W'($signed(in_item.opb[k]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vdiff[i] = SUM_W'(prod_r[2*i]) - SUM_W'(prod_r[2*i+1]);
      vtot[i]  = (vdiff[i] >>> FRAC_BITS) + SUM_W'($signed(it1_r.base[i]));
    end
    dsum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[4]);
    dsh  = dsum >>> FRAC_BITS;
    sq   = $unsigned(prod_r[0]) + $unsigned(prod_r[2]) + $unsigned(prod_r[4]);

    pay2_nxt      = '0;
    pay2_nxt.kind = it1_r.kind;
    pay2_nxt.sq   = sq;
    pay2_nxt.num  = it1_r.num;
    pay2_nxt.neg  = it1_r.neg;
    pay2_nxt.den  = it1_r.den;
    unique case (it1_r.kind)
      K_DIRECT: begin
        pay2_nxt.res = it1_r.res;
      end
      K_PROD: begin
        for (int i = 0; i < 3; i++) begin
          pay2_nxt.res.r[i] = clamp_word(vtot[i]);
          pay2_nxt.res.sat  = pay2_nxt.res.sat | over_word(vtot[i]);
        end
      end
      K_DOT: begin
        pay2_nxt.res.sc  = clamp_word(dsh);
        pay2_nxt.res.sat = over_word(dsh);
      end
      K_EQUAL: begin
        pay2_nxt.res.eq = !it1_r.far && (sq < $unsigned(prod_r[1]));
      end
      default: begin
        pay2_nxt.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    it1_r  <= in_item;
    prod_r <= prod_nxt;
    pay2_r <= pay2_nxt;
  end

endmodule

// File: sv/v3a_root.sv
// v3a_root: integer square root of the 64-bit sum of squares, one result bit
// per pipeline stage; uses v3a_pkg
module v3a_root import v3a_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  back_t             in_pay,
  output logic              out_valid,
  output back_t             out_pay,
  output logic [ROOT_W-1:0] out_root
);

  logic              val_r [ROOT_STEPS];
  back_t             pay_r [ROOT_STEPS];
  logic [PROD_W-1:0] rem_r [ROOT_STEPS];
  logic [PROD_W-1:0] res_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [PROD_W-1:0] STEP_BIT = PROD_W'(1) << (PROD_W - 2 - 2 * k);
    logic              v_in;
    back_t             pay_in;
    logic [PROD_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;
    logic              take;

    if (k == 0) begin : g_src
      assign v_in   = in_valid;
      assign pay_in = in_pay;
      assign rem_in = in_pay.sq;
      assign res_in = '0;
    end else begin : g_src
      assign v_in   = val_r[k-1];
      assign pay_in = pay_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial   = res_in + STEP_BIT;
      take    = (rem_in >= trial);
      rem_nxt = take ? rem_in - trial : rem_in;
      res_nxt = take ? (res_in >> 1) + STEP_BIT : (res_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      pay_r[k] <= pay_in;
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign out_valid = val_r[ROOT_STEPS-1];
  assign out_pay   = pay_r[ROOT_STEPS-1];
  assign out_root  = res_r[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// File: sv/v3a_divide.sv
// v3a_divide: three-lane restoring divider, one quotient bit per stage, plus
// the final sign, saturation and status stage; uses v3a_pkg
module v3a_divide import v3a_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  back_t             in_pay,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  output word_t             out_rx,
  output word_t             out_ry,
  output word_t             out_rz,
  output word_t             out_scalar_out,
  output logic              out_equal_flag,
  output logic [1:0]        out_status
);

  back_t                   ent;
  logic signed [SUM_W-1:0] root_s;
  logic                    val_r [NUM_W];
  back_t                   pay_r [NUM_W];
  logic [2:0][DEN_W-1:0]   rem_r [NUM_W];
  logic [2:0][NUM_W-1:0]   nq_r  [NUM_W];
  res_t                    fin;
  logic signed [SUM_W-1:0] qs [3];
  logic                    use_q;
  logic                    ov_r;
  res_t                    fin_r;

  always_comb begin
    ent    = in_pay;
    root_s = SUM_W'($signed({1'b0, in_root}));
    if (in_pay.kind == K_UNIT) begin
      ent.den = DEN_W'(in_root);
    end
    if (in_pay.kind == K_NORM) begin
      ent.res.sc  = clamp_word(root_s);
      ent.res.sat = over_word(root_s);
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic                  v_in;
    back_t                 pay_in;
    logic [2:0][DEN_W-1:0] rem_in, rem_nxt;
    logic [2:0][NUM_W-1:0] nq_in, nq_nxt;
    logic [REM_W-1:0]      trial [3];
    logic                  ge [3];

    if (k == 0) begin : g_src
      assign v_in   = in_valid;
      assign pay_in = ent;
      assign rem_in = '0;
      assign nq_in  = ent.num;
    end else begin : g_src
      assign v_in   = val_r[k-1];
      assign pay_in = pay_r[k-1];
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i]   = {rem_in[i], nq_in[i][NUM_W-1]};
        ge[i]      = (trial[i] >= {1'b0, pay_in.den});
        rem_nxt[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, pay_in.den}) : trial[i][DEN_W-1:0];
        nq_nxt[i]  = {nq_in[i][NUM_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      pay_r[k] <= pay_in;
      rem_r[k] <= rem_nxt;
      nq_r[k]  <= nq_nxt;
    end
  end

  always_comb begin
    fin   = pay_r[NUM_W-1].res;
    use_q = ((pay_r[NUM_W-1].kind == K_DIV) || (pay_r[NUM_W-1].kind == K_UNIT))
         && (pay_r[NUM_W-1].den != '0);
    for (int i = 0; i < 3; i++) begin
      qs[i] = SUM_W'($signed({1'b0, nq_r[NUM_W-1][i]}));
      if (pay_r[NUM_W-1].neg[i]) begin
        qs[i] = -qs[i];
      end
      if (use_q) begin
        fin.r[i] = clamp_word(qs[i]);
        fin.sat  = fin.sat | over_word(qs[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= val_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin;
  end

  assign out_valid      = ov_r;
  assign out_rx         = fin_r.r[0];
  assign out_ry         = fin_r.r[1];
  assign out_rz         = fin_r.r[2];
  assign out_scalar_out = fin_r.sc;
  assign out_equal_flag = fin_r.eq;
  assign out_status     = fin_r.dz ? ST_DIV_ZERO : (fin_r.sat ? ST_SAT : ST_OK);

endmodule

// File: sv/vector3_fixed_point_alu_core.sv
// vector3_fixed_point_alu_core: top level of the three-component fixed-point vector alu
// depends on v3a_pkg, v3a_front, v3a_queue, v3a_arith, v3a_root, v3a_divide
//
// usage:
//   a command is taken at a rising edge with start high and busy low; the
//   command code, vectors a and b and the scalar sit on the in_ ports
//   the tolerance register is written through cfg_valid/cfg_ready with
//   cfg_equal_tolerance; cfg_ready is always high, write only while idle
//   every command gives one result, shown for exactly one cycle with
//   out_valid high; the receiver cannot hold it off
//   the data format is Q16.16; a command passes the queue register, the
//   multiply and sum registers, 32 square root steps and one divider step
//   per quotient bit, then the output register
//   throughput is one command per cycle; every command walks the same
//   pipeline, so results leave in order and busy stays low in practice
//   reset clears the valid bits and the queue and sets the tolerance to 1
module vector3_fixed_point_alu_core import v3a_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  word_t             in_ax,
  input  word_t             in_ay,
  input  word_t             in_az,
  input  word_t             in_bx,
  input  word_t             in_by,
  input  word_t             in_bz,
  input  word_t             in_scalar_in,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TOL_W-1:0]  cfg_equal_tolerance,
  output logic              out_valid,
  output word_t             out_rx,
  output word_t             out_ry,
  output word_t             out_rz,
  output word_t             out_scalar_out,
  output logic              out_equal_flag,
  output logic [1:0]        out_status
);

  logic              q_full;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             pop_item;
  logic              ar_valid;
  back_t             ar_pay;
  logic              rt_valid;
  back_t             rt_pay;
  logic [ROOT_W-1:0] rt_root;

  assign busy = q_full;

  v3a_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .q_full              (q_full),
    .in_command          (in_command),
    .in_ax               (in_ax),
    .in_ay               (in_ay),
    .in_az               (in_az),
    .in_bx               (in_bx),
    .in_by               (in_by),
    .in_bz               (in_bz),
    .in_scalar_in        (in_scalar_in),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_equal_tolerance (cfg_equal_tolerance),
    .push                (push),
    .push_item           (push_item)
  );

  v3a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  v3a_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop),
    .in_item   (pop_item),
    .out_valid (ar_valid),
    .out_pay   (ar_pay)
  );

  v3a_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ar_valid),
    .in_pay    (ar_pay),
    .out_valid (rt_valid),
    .out_pay   (rt_pay),
    .out_root  (rt_root)
  );

  v3a_divide u_divide (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rt_valid),
    .in_pay         (rt_pay),
    .in_root        (rt_root),
    .out_valid      (out_valid),
    .out_rx         (out_rx),
    .out_ry         (out_ry),
    .out_rz         (out_rz),
    .out_scalar_out (out_scalar_out),
    .out_equal_flag (out_equal_flag),
    .out_status     (out_status)
  );

endmodule
